>>> src/tidt_pkg.sv
// tidt_pkg: shared types and codes for the thread id translation table
// holds transaction payload structs, table entry layout, mode and status codes
// no dependencies
package tidt_pkg;

    typedef logic [1:0] t_mode;
    typedef logic [1:0] t_status;

    localparam t_mode MODE_REGISTER   = 2'd0;
    localparam t_mode MODE_UNREGISTER = 2'd1;
    localparam t_mode MODE_LOOKUP     = 2'd2;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_DUP      = 2'd1;
    localparam t_status ST_FULL     = 2'd2;
    localparam t_status ST_NOTFOUND = 2'd3;

    typedef struct packed {
        t_mode       mode;
        logic [63:0] managed_id;
        logic [31:0] thread_nid;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] found_nid;
    } t_rsp;

    typedef struct packed {
        logic        free;
        logic [31:0] native;
        logic [63:0] key;
    } t_entry;

endpackage

>>> src/tidt_stream_if.sv
// tidt_stream_if: valid/ready channel carrying one payload per transaction
// payload type is a parameter; no other dependencies
interface tidt_stream_if #(
    parameter type t_payload = logic
) ();

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

>>> src/tidt_ram.sv
// tidt_ram: generic single write port, single read port ram with registered read
// no dependencies
module tidt_ram #(
    parameter int   WIDTH = 8,
    parameter int   DEPTH = 16,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AddrW-1:0] i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AddrW-1:0] i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/thread_id_translation_table.sv
// thread_id_translation_table: maps 64-bit managed thread ids to 32-bit native ids
// depends on tidt_pkg, tidt_stream_if, tidt_ram
//
// usage
// - i_req (sink, payload tidt_pkg::t_req) takes one transaction: register a
//   mapping, unregister by native id, or look up by managed id
// - o_rsp (source, payload tidt_pkg::t_rsp) returns exactly one transaction per
//   request: status and, for a successful lookup, the native id
// - entries live in one ram read once per cycle; a request scans the used entries
//   in order and stops at the first deciding entry
// - a defined mode scans until a deciding entry or the end of the used entries;
//   an undefined mode skips the scan and answers without reading the table
// - one request is in work at a time; i_req.ready is high only while idle, and the
//   next request is taken the cycle after the result register loads
// - the result register holds while o_rsp.ready is low; a finished request waits
//   until the register is free, so nothing is lost when the receiver stalls
// - synchronous reset empties the table (used count zero); no clearing pass is
//   needed since entries at or above the used count are never read
module thread_id_translation_table #(
    parameter int ENTRIES = 16
) (
    input logic          i_clk,
    input logic          i_rst_n,
    tidt_stream_if.sink   i_req,
    tidt_stream_if.source o_rsp
);

    import tidt_pkg::*;

    localparam int IdxW = $clog2(ENTRIES);
    localparam int CntW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    t_state      r_state, n_state;
    t_mode       r_mode, n_mode;
    logic [63:0] r_key, n_key;
    logic [31:0] r_nid, n_nid;
    logic [CntW-1:0] r_used, n_used;
    logic [CntW-1:0] r_ridx, n_ridx;
    logic [IdxW-1:0] r_cidx, n_cidx;
    logic        r_pend, n_pend;
    t_status     r_res_status, n_res_status;
    logic [31:0] r_res_found, n_res_found;
    logic        r_out_vld, n_out_vld;
    t_rsp        r_out, n_out;

    logic            ram_we;
    logic [IdxW-1:0] ram_waddr;
    t_entry          ram_wdata;
    logic            ram_re;
    logic [IdxW-1:0] ram_raddr;
    t_entry          rd_entry;
    t_req            req;

    assign req = i_req.payload;

    tidt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (rd_entry)
    );

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_key        = r_key;
        n_nid        = r_nid;
        n_used       = r_used;
        n_ridx       = r_ridx;
        n_cidx       = r_cidx;
        n_pend       = r_pend;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_out_vld    = r_out_vld;
        n_out        = r_out;
        ram_we       = 1'b0;
        ram_waddr    = r_cidx;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = r_ridx[IdxW-1:0];

        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_mode       = req.mode;
                    n_key        = req.managed_id;
                    n_nid        = req.thread_nid;
                    n_ridx       = '0;
                    n_pend       = 1'b0;
                    n_res_found  = '0;
                    n_res_status = ST_NOTFOUND;
                    if (req.mode == MODE_REGISTER || req.mode == MODE_UNREGISTER
                        || req.mode == MODE_LOOKUP) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_SCAN: begin
                // issue next read while the previous entry is checked
                if (r_ridx < r_used) begin
                    ram_re = 1'b1;
                    n_pend = 1'b1;
                    n_cidx = r_ridx[IdxW-1:0];
                    n_ridx = r_ridx + CntW'(1);
                end else begin
                    n_pend = 1'b0;
                end

                if (r_pend) begin
                    unique case (r_mode)
                        MODE_REGISTER: begin
                            if (rd_entry.key == r_key) begin
                                n_res_status = ST_DUP;
                                n_state      = S_RESP;
                            end else if (rd_entry.free) begin
                                ram_we           = 1'b1;
                                ram_waddr        = r_cidx;
                                ram_wdata.free   = 1'b0;
                                ram_wdata.native = r_nid;
                                ram_wdata.key    = r_key;
                                n_res_status     = ST_OK;
                                n_state          = S_RESP;
                            end
                        end
                        MODE_UNREGISTER: begin
                            if (!rd_entry.free && rd_entry.native == r_nid) begin
                                ram_we           = 1'b1;
                                ram_waddr        = r_cidx;
                                ram_wdata.free   = 1'b1;
                                ram_wdata.native = rd_entry.native;
                                ram_wdata.key    = rd_entry.key;
                                n_res_status     = ST_OK;
                                n_state          = S_RESP;
                            end
                        end
                        MODE_LOOKUP: begin
                            if (rd_entry.key == r_key) begin
                                if (rd_entry.free) begin
                                    n_res_status = ST_NOTFOUND;
                                end else begin
                                    n_res_status = ST_OK;
                                    n_res_found  = rd_entry.native;
                                end
                                n_state = S_RESP;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end else if (r_ridx >= r_used) begin
                    // end of scan with no deciding entry
                    if (r_mode == MODE_REGISTER) begin
                        if (r_used < CntW'(ENTRIES)) begin
                            ram_we           = 1'b1;
                            ram_waddr        = r_used[IdxW-1:0];
                            ram_wdata.free   = 1'b0;
                            ram_wdata.native = r_nid;
                            ram_wdata.key    = r_key;
                            n_used           = r_used + CntW'(1);
                            n_res_status     = ST_OK;
                        end else begin
                            n_res_status = ST_FULL;
                        end
                    end else begin
                        n_res_status = ST_NOTFOUND;
                    end
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld       = 1'b1;
                    n_out.status    = r_res_status;
                    n_out.found_nid = (r_res_status == ST_OK) ? r_res_found : '0;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_nid        <= n_nid;
        r_ridx       <= n_ridx;
        r_cidx       <= n_cidx;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_out        <= n_out;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.payload = r_out;

endmodule

>>> bench/thread_id_translation_table_checker.sv
`timescale 1ns / 100ps
// thread_id_translation_table_checker: watches request and result channels of the table,
// predicts each result from its own copy of the table and compares field by field
// depends on tidt_pkg
module thread_id_translation_table_checker #(
    parameter int ENTRIES = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_ready,
    input  tidt_pkg::t_req i_req,
    input  logic           i_rsp_valid,
    input  logic           i_rsp_ready,
    input  tidt_pkg::t_rsp i_rsp,
    output int             o_fail_count,
    output int             o_pending
);

    import tidt_pkg::*;

    logic [63:0] tbl_key    [ENTRIES];
    logic [31:0] tbl_native [ENTRIES];
    logic        tbl_free   [ENTRIES];
    int unsigned tbl_used;

    t_rsp awaited_results[$];
    int   mismatches;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t: result mismatch on %s: got %0h, expected %0h", $realtime, what, got,
                 want);
    endtask

    function automatic t_rsp apply_to_table(input t_req r);
        t_rsp res;
        int   i;
        bit   done;
        res.status    = ST_NOTFOUND;
        res.found_nid = '0;
        done          = 1'b0;
        case (r.mode)
            MODE_REGISTER: begin
                for (i = 0; i < tbl_used && !done; i++) begin
                    if (tbl_key[i] == r.managed_id) begin
                        res.status = ST_DUP;
                        done       = 1'b1;
                    end else if (tbl_free[i]) begin
                        tbl_key[i]    = r.managed_id;
                        tbl_native[i] = r.thread_nid;
                        tbl_free[i]   = 1'b0;
                        res.status    = ST_OK;
                        done          = 1'b1;
                    end
                end
                if (!done) begin
                    if (tbl_used >= ENTRIES) begin
                        res.status = ST_FULL;
                    end else begin
                        tbl_key[tbl_used]    = r.managed_id;
                        tbl_native[tbl_used] = r.thread_nid;
                        tbl_free[tbl_used]   = 1'b0;
                        tbl_used++;
                        res.status = ST_OK;
                    end
                end
            end
            MODE_UNREGISTER: begin
                for (i = 0; i < tbl_used && !done; i++) begin
                    if (!tbl_free[i] && tbl_native[i] == r.thread_nid) begin
                        tbl_free[i] = 1'b1;
                        res.status  = ST_OK;
                        done        = 1'b1;
                    end
                end
            end
            MODE_LOOKUP: begin
                for (i = 0; i < tbl_used && !done; i++) begin
                    if (tbl_key[i] == r.managed_id) begin
                        done = 1'b1;
                        if (!tbl_free[i]) begin
                            res.status    = ST_OK;
                            res.found_nid = tbl_native[i];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            tbl_used = 0;
            awaited_results.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                awaited_results.push_back(apply_to_table(i_req));
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected transaction", 64'(i_rsp), 64'(0));
                end else begin
                    want = awaited_results.pop_front();
                    if (i_rsp.status !== want.status) begin
                        report_mismatch("status", 64'(i_rsp.status), 64'(want.status));
                    end
                    if (i_rsp.found_nid !== want.found_nid) begin
                        report_mismatch("found_nid", 64'(i_rsp.found_nid),
                                        64'(want.found_nid));
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited_results.size();
    end

endmodule

>>> bench/thread_id_translation_table_test.sv
`timescale 1ns / 100ps
// thread_id_translation_table_test: clock, reset and stimulus for the translation table
// depends on tidt_pkg, tidt_stream_if, thread_id_translation_table and its checker
module thread_id_translation_table_test;
    import tidt_pkg::*;

    localparam int    ENTRIES        = 16;
    localparam int    RANDOM_ITEMS   = 1850;
    localparam int    POOL_SIZE      = 26;
    localparam int    CYCLE_LIMIT    = 400000;
    localparam int    HOLD_CYCLES    = 300;
    localparam t_mode MODE_UNDEFINED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic hold_rsp;
    bit   rand_phase;
    int   fail_count;
    int   pending;
    int   cycles;
    int   req_calm;
    int   rsp_calm;

    logic [63:0] key_pool    [POOL_SIZE];
    logic [31:0] native_pool [POOL_SIZE];

    tidt_stream_if #(.t_payload(t_req)) req_if ();
    tidt_stream_if #(.t_payload(t_rsp)) rsp_if ();

    thread_id_translation_table #(
        .ENTRIES(ENTRIES)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    thread_id_translation_table_checker #(
        .ENTRIES(ENTRIES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_if.valid),
        .i_req_ready (req_if.ready),
        .i_req       (req_if.payload),
        .i_rsp_valid (rsp_if.valid),
        .i_rsp_ready (rsp_if.ready),
        .i_rsp       (rsp_if.payload),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(20, 80);
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic logic [63:0] pick_key();
        if ($urandom_range(0, 9) == 0) begin
            return {$urandom, $urandom};
        end
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic logic [31:0] pick_native();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom;
        end
        return native_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic send_request(input t_mode mode, input logic [63:0] key,
                                input logic [31:0] native);
        int   gap;
        t_req r;
        gap          = draw_gap(req_calm);
        r.mode       = mode;
        r.managed_id = key;
        r.thread_nid = native;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // result side: random stalls per transaction, plus one long hold-off
    initial begin
        int wait_cycles;
        rsp_if.ready <= 1'b0;
        forever begin
            wait_cycles = draw_gap(rsp_calm);
            while (hold_rsp || wait_cycles > 0) begin
                rsp_if.ready <= 1'b0;
                @(posedge i_clk);
                if (wait_cycles > 0) begin
                    wait_cycles--;
                end
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
        end
    end

    initial begin
        hold_rsp <= 1'b0;
        wait (rand_phase);
        repeat (50) @(posedge i_clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rsp <= 1'b0;
    end

    initial begin
        int          n;
        int          r;
        int          reg_w;
        int          unreg_w;
        logic [63:0] k;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        i_rst_n        <= 1'b0;
        req_calm       = 0;
        rsp_calm       = 0;
        rand_phase     = 1'b0;
        key_pool[0]    = '0;
        key_pool[1]    = '1;
        native_pool[0] = '0;
        native_pool[1] = '1;
        for (n = 2; n < POOL_SIZE; n++) begin
            key_pool[n]    = {$urandom, $urandom};
            native_pool[n] = $urandom;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, undefined mode
        send_request(MODE_LOOKUP, '0, '0);
        send_request(MODE_UNREGISTER, '1, '0);
        send_request(MODE_UNDEFINED, '1, '1);
        // extremes, duplicate, lookup of a freed entry, duplicate on a freed entry
        send_request(MODE_REGISTER, '1, '1);
        send_request(MODE_REGISTER, '0, '0);
        send_request(MODE_LOOKUP, '1, '0);
        send_request(MODE_REGISTER, '1, 32'h5);
        send_request(MODE_UNREGISTER, '0, '1);
        send_request(MODE_LOOKUP, '1, '1);
        send_request(MODE_REGISTER, '1, 32'h7);
        // reuse of the freed entry, then fill to full
        k = {$urandom, $urandom};
        send_request(MODE_REGISTER, k, $urandom);
        for (n = 0; n < ENTRIES - 2; n++) begin
            send_request(MODE_REGISTER, {$urandom, $urandom}, $urandom);
        end
        send_request(MODE_REGISTER, {$urandom, $urandom}, $urandom);

        rand_phase = 1'b1;
        reg_w      = 40;
        unreg_w    = 20;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                reg_w   = $urandom_range(20, 70);
                unreg_w = $urandom_range(10, 25);
            end
            r = $urandom_range(0, 99);
            if (r < 5) begin
                send_request(MODE_UNDEFINED, {$urandom, $urandom}, $urandom);
            end else if (r < 5 + reg_w) begin
                send_request(MODE_REGISTER, pick_key(), pick_native());
            end else if (r < 5 + reg_w + unreg_w) begin
                send_request(MODE_UNREGISTER, {$urandom, $urandom}, pick_native());
            end else begin
                send_request(MODE_LOOKUP, pick_key(), $urandom);
            end
        end
        req_if.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (ENTRIES + 12) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
